// File: rtl/slbc_pkg.sv
// ============================================================================
// slbc_pkg
// Shared types and constants for the status LED blink controller.
// ============================================================================
package slbc_pkg;

    localparam int PHASE_W   = 16;
    localparam int RUN_W     = 32;
    localparam int LOOPS_W   = 24;
    localparam int MODE_IN_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 64;

    localparam logic [PHASE_W-1:0] BLINK_A_ON_RST  = 16'd300;
    localparam logic [PHASE_W-1:0] BLINK_A_OFF_RST = 16'd700;
    localparam logic [PHASE_W-1:0] BLINK_B_ON_RST  = 16'd1000;
    localparam logic [PHASE_W-1:0] BLINK_B_OFF_RST = 16'd1000;
    localparam logic [PHASE_W-1:0] STEADY_RST      = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_A_ON  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_A_OFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_B_ON  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_B_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY      = 3'd4;

    typedef enum logic [1:0] {
        MODE_BLINK_A = 2'd0,
        MODE_BLINK_B = 2'd1,
        MODE_ON      = 2'd2,
        MODE_OFF     = 2'd3
    } mode_t;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_MODE = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [PHASE_W-1:0] blink_a_on_ms;
        logic [PHASE_W-1:0] blink_a_off_ms;
        logic [PHASE_W-1:0] blink_b_on_ms;
        logic [PHASE_W-1:0] blink_b_off_ms;
        logic [PHASE_W-1:0] steady_period_ms;
    } cfg_t;

    typedef struct packed {
        req_type_t              req_type;
        logic [MODE_IN_W-1:0]   mode_value;
    } item_t;

    typedef struct packed {
        logic                   led_level;
        mode_t                  mode_echo;
        logic                   phase_now;
        logic [LOOPS_W-1:0]     completed_loops;
        logic [RUN_W-1:0]       run_time_ms;
        logic                   phase_expired;
    } result_t;

endpackage

// File: rtl/slbc_cfg_regs.sv
// ============================================================================
// slbc_cfg_regs
// Phase length registers, written through the plain write port.
// ============================================================================
module slbc_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [slbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slbc_pkg::PHASE_W-1:0]    cfg_data,
    output slbc_pkg::cfg_t                  cfg
);

    slbc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_a_on_ms    <= slbc_pkg::BLINK_A_ON_RST;
            cfg_reg.blink_a_off_ms   <= slbc_pkg::BLINK_A_OFF_RST;
            cfg_reg.blink_b_on_ms    <= slbc_pkg::BLINK_B_ON_RST;
            cfg_reg.blink_b_off_ms   <= slbc_pkg::BLINK_B_OFF_RST;
            cfg_reg.steady_period_ms <= slbc_pkg::STEADY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                slbc_pkg::CFG_BLINK_A_ON:  cfg_reg.blink_a_on_ms    <= cfg_data;
                slbc_pkg::CFG_BLINK_A_OFF: cfg_reg.blink_a_off_ms   <= cfg_data;
                slbc_pkg::CFG_BLINK_B_ON:  cfg_reg.blink_b_on_ms    <= cfg_data;
                slbc_pkg::CFG_BLINK_B_OFF: cfg_reg.blink_b_off_ms   <= cfg_data;
                slbc_pkg::CFG_STEADY:      cfg_reg.steady_period_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/slbc_in_reg.sv
// ============================================================================
// slbc_in_reg
// Input register: holds one accepted word until the core takes it.
// ============================================================================
module slbc_in_reg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [slbc_pkg::TDATA_IN_W-1:0] s_axis_tdata,  // [7:0] mode_value
    input  logic                            s_axis_tuser,  // [0] req_type
    input  logic                            take,
    output logic                            valid,
    output slbc_pkg::item_t                 item
);

    logic            valid_reg;
    slbc_pkg::item_t item_reg;

    assign s_axis_tready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.req_type   <= slbc_pkg::req_type_t'(s_axis_tuser);
            item_reg.mode_value <= s_axis_tdata;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: rtl/slbc_core.sv
// ============================================================================
// slbc_core
// Blink state: phase countdown, mode changes, run time and loop counters.
// ============================================================================
module slbc_core
#(
    parameter int LOOP_COUNT_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  slbc_pkg::item_t     item,
    input  slbc_pkg::cfg_t      cfg,
    output slbc_pkg::result_t   result
);

    slbc_pkg::mode_t                mode_reg, mode_next;
    logic                           phase_reg, phase_next;
    logic [slbc_pkg::PHASE_W-1:0]   len_reg, len_next;
    logic [slbc_pkg::PHASE_W-1:0]   rem_reg, rem_next;
    logic [slbc_pkg::RUN_W-1:0]     run_reg, run_next;
    logic [LOOP_COUNT_BITS-1:0]     loop_reg, loop_next;
    logic                           led_reg, led_next;
    logic                           expired;

    slbc_pkg::mode_t                req_mode;
    logic                           req_steady;
    logic                           cur_steady;
    logic [slbc_pkg::PHASE_W-1:0]   req_on_len;
    logic [slbc_pkg::PHASE_W-1:0]   cur_on_len;
    logic [slbc_pkg::PHASE_W-1:0]   cur_off_len;
    logic [31:0]                    loop_ext;

    assign req_mode   = (item.mode_value[slbc_pkg::MODE_IN_W-1:2] != '0)
                        ? slbc_pkg::MODE_BLINK_A
                        : slbc_pkg::mode_t'(item.mode_value[1:0]);
    assign req_steady = (req_mode == slbc_pkg::MODE_ON) || (req_mode == slbc_pkg::MODE_OFF);
    assign cur_steady = (mode_reg == slbc_pkg::MODE_ON) || (mode_reg == slbc_pkg::MODE_OFF);
    assign req_on_len = (req_mode == slbc_pkg::MODE_BLINK_B) ? cfg.blink_b_on_ms
                                                             : cfg.blink_a_on_ms;
    assign cur_on_len = (mode_reg == slbc_pkg::MODE_BLINK_B) ? cfg.blink_b_on_ms
                                                             : cfg.blink_a_on_ms;
    assign cur_off_len = (mode_reg == slbc_pkg::MODE_BLINK_B) ? cfg.blink_b_off_ms
                                                              : cfg.blink_a_off_ms;

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        run_next   = run_reg;
        loop_next  = loop_reg;
        led_next   = led_reg;
        expired    = 1'b0;
        priority if (!fire)
        begin
        end
        else if (item.req_type == slbc_pkg::REQ_MODE)
        begin
            if (req_mode != mode_reg)
            begin
                mode_next  = req_mode;
                phase_next = 1'b0;
                if (req_steady)
                begin
                    led_next = (req_mode == slbc_pkg::MODE_ON);
                    len_next = cfg.steady_period_ms;
                    rem_next = cfg.steady_period_ms;
                end
                else
                begin
                    led_next = 1'b1;
                    len_next = req_on_len;
                    rem_next = req_on_len;
                end
            end
        end
        else if (rem_reg <= slbc_pkg::PHASE_W'(1))
        begin
            expired  = 1'b1;
            run_next = run_reg + slbc_pkg::RUN_W'(len_reg);
            priority if (cur_steady)
            begin
                led_next   = (mode_reg == slbc_pkg::MODE_ON);
                phase_next = 1'b0;
                len_next   = cfg.steady_period_ms;
                rem_next   = cfg.steady_period_ms;
            end
            else if (!phase_reg)
            begin
                phase_next = 1'b1;
                led_next   = 1'b0;
                len_next   = cur_off_len;
                rem_next   = cur_off_len;
            end
            else
            begin
                phase_next = 1'b0;
                led_next   = 1'b1;
                loop_next  = loop_reg + LOOP_COUNT_BITS'(1);
                len_next   = cur_on_len;
                rem_next   = cur_on_len;
            end
        end
        else
        begin
            rem_next = rem_reg - slbc_pkg::PHASE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= slbc_pkg::MODE_BLINK_A;
            phase_reg <= 1'b0;
            len_reg   <= slbc_pkg::BLINK_A_ON_RST;
            rem_reg   <= slbc_pkg::BLINK_A_ON_RST;
            run_reg   <= '0;
            loop_reg  <= '0;
            led_reg   <= 1'b1;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            run_reg   <= run_next;
            loop_reg  <= loop_next;
            led_reg   <= led_next;
        end
    end

    assign loop_ext = 32'(loop_next);

    always_comb
    begin
        result.led_level       = led_next;
        result.mode_echo       = mode_next;
        result.phase_now       = phase_next;
        result.completed_loops = loop_ext[slbc_pkg::LOOPS_W-1:0];
        result.run_time_ms     = run_next;
        result.phase_expired   = expired;
    end

endmodule

// File: rtl/slbc_out_reg.sv
// ============================================================================
// slbc_out_reg
// Result register driving the master-side stream.
// ============================================================================
module slbc_out_reg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  slbc_pkg::result_t                   result,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] led_level, [2:1] mode_echo, [3] phase_now, [27:4] completed_loops,
    // [59:28] run_time_ms, [60] phase_expired, [63:61] zero
    output logic [slbc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

    logic               valid_reg;
    slbc_pkg::result_t  res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {3'b000,
                            res_reg.phase_expired,
                            res_reg.run_time_ms,
                            res_reg.completed_loops,
                            res_reg.phase_now,
                            res_reg.mode_echo,
                            res_reg.led_level};

endmodule

// File: rtl/status_led_blink_controller.sv
// ============================================================================
// status_led_blink_controller
// LED blink pattern generator driven by millisecond ticks and mode writes.
// ============================================================================
// Input stream: one word per tick (tuser = 0) or mode write (tuser = 1,
// tdata = raw mode byte). Every input word yields exactly one result word
// on the output stream with the LED level, mode, phase, loop count, run time
// and a phase-expired flag, all as they stand after that word.
// Phase lengths come from five registers on the write port; a new value is
// used when the next phase starts. Write them while the stream is idle.
// Path: an accepted word waits in the input register, and its result is then
// held in the result register.
// Throughput: one word per cycle while m_axis_tready is high; the state
// update is a single decrement, compare and 32-bit add between the two registers.
// Reset: registers return to 300/700/1000/1000/1000 ms, mode blink A in its
// on phase with the LED on, counters cleared, both streams empty.
// Stall: a result waiting on m_axis_tready holds; an empty input register
// takes at most one more word, then s_axis_tready stays low until the result
// is taken.
// ============================================================================
module status_led_blink_controller
#(
    parameter int LOOP_COUNT_BITS = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [slbc_pkg::TDATA_IN_W-1:0]     s_axis_tdata,  // [7:0] mode_value
    input  logic                                s_axis_tuser,  // [0] req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] led_level, [2:1] mode_echo, [3] phase_now, [27:4] completed_loops,
    // [59:28] run_time_ms, [60] phase_expired, [63:61] zero
    output logic [slbc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input  logic                                cfg_wr_en,
    input  logic [slbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slbc_pkg::PHASE_W-1:0]        cfg_data
);

    slbc_pkg::cfg_t     cfg;
    slbc_pkg::item_t    item;
    slbc_pkg::result_t  result;
    logic               in_valid;
    logic               advance;

    assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);

    slbc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slbc_in_reg u_in
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (advance),
        .valid         (in_valid),
        .item          (item)
    );

    slbc_core
    #(
        .LOOP_COUNT_BITS (LOOP_COUNT_BITS)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    slbc_out_reg u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .result        (result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: rtl/slbc_checker.sv
// ============================================================================
// slbc_checker
// Port-level checks on the result stream of the blink controller.
// ============================================================================
module slbc_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [slbc_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:61] == 3'b000)
        else $error("pad bits set");

    a_steady_on: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] == slbc_pkg::MODE_ON
        |-> m_axis_tdata[0] && !m_axis_tdata[3])
        else $error("steady on mode with LED off or off phase");

    a_steady_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] == slbc_pkg::MODE_OFF
        |-> !m_axis_tdata[0] && !m_axis_tdata[3])
        else $error("steady off mode with LED on or off phase");

    a_blink_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[0] != m_axis_tdata[3])
        else $error("blink LED level does not follow phase");

endmodule

bind status_led_blink_controller slbc_checker u_slbc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/status_led_blink_controller_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// status_led_blink_controller_tb
// Self-checking bench for the status LED blink controller.
// Ticks and mode writes go in on the input stream. A shadow model of the
// mode, phase, counters and registers predicts the result word for each
// accepted word. The results are checked field by field in order. Both
// streams idle and stall at random. Phase registers are rewritten between
// rounds while the stream is drained.
// ============================================================================
module status_led_blink_controller_tb;

    localparam int LOOP_COUNT_BITS = 24;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ROUNDS          = 6;
    localparam int WORDS_PER_ROUND = 250;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [slbc_pkg::TDATA_IN_W-1:0]      s_axis_tdata  = '0;    // [7:0] mode_value
    logic                                 s_axis_tuser  = 1'b0;  // [0] req_type
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    // [0] led_level, [2:1] mode_echo, [3] phase_now, [27:4] completed_loops,
    // [59:28] run_time_ms, [60] phase_expired, [63:61] zero
    logic [slbc_pkg::TDATA_OUT_W-1:0]     m_axis_tdata;
    logic                                 cfg_wr_en     = 1'b0;
    logic [slbc_pkg::CFG_IDX_W-1:0]       cfg_index     = '0;
    logic [slbc_pkg::PHASE_W-1:0]         cfg_data      = '0;

    status_led_blink_controller #(
        .LOOP_COUNT_BITS (LOOP_COUNT_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow state
    slbc_pkg::cfg_t                 phase_regs;
    slbc_pkg::mode_t                cur_mode;
    logic                           cur_phase;
    logic [slbc_pkg::PHASE_W-1:0]   cur_len;
    logic [slbc_pkg::PHASE_W-1:0]   remain_ms;
    logic [slbc_pkg::RUN_W-1:0]     run_acc;
    logic [LOOP_COUNT_BITS-1:0]     loop_acc;
    logic                           led_on;

    slbc_pkg::result_t result_q[$];
    int      errors        = 0;
    int      n_words       = 0;
    int      n_results     = 0;
    int      n_expired     = 0;
    int      n_mode_writes = 0;
    int      n_reg_writes  = 0;
    bit      no_idle       = 1'b0;
    int      stall_left    = 0;
    int      quiet_cycles  = 0;

    function automatic logic [slbc_pkg::PHASE_W-1:0] on_len(input slbc_pkg::mode_t m);
        return (m == slbc_pkg::MODE_BLINK_B) ? phase_regs.blink_b_on_ms
                                             : phase_regs.blink_a_on_ms;
    endfunction

    function automatic void arm_phase(input logic [slbc_pkg::PHASE_W-1:0] len);
        cur_len   = len;
        remain_ms = len;
    endfunction

    function automatic slbc_pkg::result_t step_led(input slbc_pkg::req_type_t rt,
                                                   input logic [7:0] mv);
        slbc_pkg::result_t r;
        slbc_pkg::mode_t   m;
        logic              hit;
        hit = 1'b0;
        if (rt == slbc_pkg::REQ_MODE)
        begin
            m = (mv > {6'd0, slbc_pkg::MODE_OFF}) ? slbc_pkg::MODE_BLINK_A
                                                  : slbc_pkg::mode_t'(mv[1:0]);
            if (m != cur_mode)
            begin
                cur_mode  = m;
                cur_phase = 1'b0;
                if (m == slbc_pkg::MODE_ON || m == slbc_pkg::MODE_OFF)
                begin
                    led_on = (m == slbc_pkg::MODE_ON);
                    arm_phase(phase_regs.steady_period_ms);
                end
                else
                begin
                    led_on = 1'b1;
                    arm_phase(on_len(m));
                end
            end
        end
        else if (remain_ms <= 1)
        begin
            hit     = 1'b1;
            run_acc = run_acc + slbc_pkg::RUN_W'(cur_len);
            if (cur_mode == slbc_pkg::MODE_ON || cur_mode == slbc_pkg::MODE_OFF)
            begin
                led_on    = (cur_mode == slbc_pkg::MODE_ON);
                cur_phase = 1'b0;
                arm_phase(phase_regs.steady_period_ms);
            end
            else if (cur_phase == 1'b0)
            begin
                cur_phase = 1'b1;
                led_on    = 1'b0;
                arm_phase((cur_mode == slbc_pkg::MODE_BLINK_B) ? phase_regs.blink_b_off_ms
                                                               : phase_regs.blink_a_off_ms);
            end
            else
            begin
                cur_phase = 1'b0;
                led_on    = 1'b1;
                loop_acc  = loop_acc + 1'b1;
                arm_phase(on_len(cur_mode));
            end
        end
        else
        begin
            remain_ms = remain_ms - 1'b1;
        end
        r.led_level       = led_on;
        r.mode_echo       = cur_mode;
        r.phase_now       = cur_phase;
        r.completed_loops = slbc_pkg::LOOPS_W'(loop_acc);
        r.run_time_ms     = run_acc;
        r.phase_expired   = hit;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [slbc_pkg::PHASE_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return slbc_pkg::PHASE_W'($urandom_range(1, 12));
        if (r < 88)
            return '0;
        if (r < 95)
            return '1;
        return slbc_pkg::PHASE_W'($urandom);
    endfunction

    // sends one word; tvalid stays high after acceptance so back-to-back words
    // never see a low/high pair in one step
    task automatic send_word(input slbc_pkg::req_type_t rt, input logic [7:0] mv);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rt;
        s_axis_tdata  <= mv;
        do
            @(posedge clk);
        while (!s_axis_tready);
        result_q.push_back(step_led(rt, mv));
        n_words++;
        if (rt == slbc_pkg::REQ_MODE)
            n_mode_writes++;
    endtask

    task automatic tick();
        send_word(slbc_pkg::REQ_TICK, 8'($urandom));
    endtask

    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [slbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slbc_pkg::PHASE_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            slbc_pkg::CFG_BLINK_A_ON:  phase_regs.blink_a_on_ms    = val;
            slbc_pkg::CFG_BLINK_A_OFF: phase_regs.blink_a_off_ms   = val;
            slbc_pkg::CFG_BLINK_B_ON:  phase_regs.blink_b_on_ms    = val;
            slbc_pkg::CFG_BLINK_B_OFF: phase_regs.blink_b_off_ms   = val;
            slbc_pkg::CFG_STEADY:      phase_regs.steady_period_ms = val;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic write_all(input logic [slbc_pkg::PHASE_W-1:0] a_on,
                             input logic [slbc_pkg::PHASE_W-1:0] a_off,
                             input logic [slbc_pkg::PHASE_W-1:0] b_on,
                             input logic [slbc_pkg::PHASE_W-1:0] b_off,
                             input logic [slbc_pkg::PHASE_W-1:0] steady);
        write_reg(slbc_pkg::CFG_BLINK_A_ON, a_on);
        write_reg(slbc_pkg::CFG_BLINK_A_OFF, a_off);
        write_reg(slbc_pkg::CFG_BLINK_B_ON, b_on);
        write_reg(slbc_pkg::CFG_BLINK_B_OFF, b_off);
        write_reg(slbc_pkg::CFG_STEADY, steady);
    endtask

    task automatic test_reset_defaults();
        repeat (3) tick();
        send_word(slbc_pkg::REQ_MODE, {6'd0, slbc_pkg::MODE_BLINK_A});
        drain_stream();
        write_all(16'd1, 16'd2, 16'd0, 16'd3, 16'd2);
    endtask

    task automatic test_blink_b_zero_phase();
        send_word(slbc_pkg::REQ_MODE, {6'd0, slbc_pkg::MODE_BLINK_B});
        repeat (5) tick();
        send_word(slbc_pkg::REQ_MODE, {6'd0, slbc_pkg::MODE_BLINK_B});
    endtask

    task automatic test_mode_fallback();
        send_word(slbc_pkg::REQ_MODE, 8'd4);
        repeat (3) tick();
        send_word(slbc_pkg::REQ_MODE, 8'hFF);
        send_word(slbc_pkg::REQ_MODE, {6'd0, slbc_pkg::MODE_BLINK_A});
    endtask

    task automatic test_steady_modes();
        send_word(slbc_pkg::REQ_MODE, {6'd0, slbc_pkg::MODE_ON});
        repeat (3) tick();
        send_word(slbc_pkg::REQ_MODE, {6'd0, slbc_pkg::MODE_OFF});
        repeat (2) tick();
        send_word(slbc_pkg::REQ_MODE, {6'd0, slbc_pkg::MODE_ON});
    endtask

    task automatic test_ignored_index();
        drain_stream();
        for (int i = int'(slbc_pkg::CFG_STEADY) + 1; i < (1 << slbc_pkg::CFG_IDX_W); i++)
            write_reg(slbc_pkg::CFG_IDX_W'(i), (i[0]) ? 16'hFFFF : 16'hA5A5);
        repeat (3) tick();
    endtask

    task automatic test_random();
        for (int rnd = 0; rnd < ROUNDS; rnd++)
        begin
            drain_stream();
            if (rnd == 0)
                write_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            else if (rnd == ROUNDS - 1)
                write_all('1, '1, '1, '1, '1);
            else
                write_all(pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
            no_idle = (rnd == 2);
            for (int k = 0; k < WORDS_PER_ROUND; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    if ($urandom_range(0, 9) < 7)
                        send_word(slbc_pkg::REQ_MODE, 8'($urandom_range(0, 3)));
                    else
                        send_word(slbc_pkg::REQ_MODE, 8'($urandom));
                end
                else
                begin
                    tick();
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // result sink with random backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (no_idle || $urandom_range(0, 99) < 70)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            m_axis_tready <= 1'b0;
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 40);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        slbc_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (result_q.size() == 0)
            begin
                $display("%0t ns: result word 0x%0h with none expected", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (want.phase_expired)
                    n_expired++;
                check_field("led_level", 32'(want.led_level), 32'(m_axis_tdata[0]));
                check_field("mode_echo", 32'(want.mode_echo), 32'(m_axis_tdata[2:1]));
                check_field("phase_now", 32'(want.phase_now), 32'(m_axis_tdata[3]));
                check_field("completed_loops", 32'(want.completed_loops),
                            32'(m_axis_tdata[27:4]));
                check_field("run_time_ms", want.run_time_ms, m_axis_tdata[59:28]);
                check_field("phase_expired", 32'(want.phase_expired), 32'(m_axis_tdata[60]));
                check_field("pad", 32'd0, 32'(m_axis_tdata[63:61]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, result_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        phase_regs = '{blink_a_on_ms:    slbc_pkg::BLINK_A_ON_RST,
                       blink_a_off_ms:   slbc_pkg::BLINK_A_OFF_RST,
                       blink_b_on_ms:    slbc_pkg::BLINK_B_ON_RST,
                       blink_b_off_ms:   slbc_pkg::BLINK_B_OFF_RST,
                       steady_period_ms: slbc_pkg::STEADY_RST};
        cur_mode  = slbc_pkg::MODE_BLINK_A;
        cur_phase = 1'b0;
        arm_phase(slbc_pkg::BLINK_A_ON_RST);
        run_acc   = '0;
        loop_acc  = '0;
        led_on    = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_blink_b_zero_phase();
        test_mode_fallback();
        test_steady_modes();
        test_ignored_index();
        test_random();

        drain_stream();
        repeat (20) @(posedge clk);

        $display("Covered %0d words (%0d mode writes), %0d results, %0d phase expiries,",
                 n_words, n_mode_writes, n_results, n_expired);
        $display("%0d register writes incl. zero, max and out-of-range index.", n_reg_writes);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
